@@ hdl/crik_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the cable robot inverse kinematics block.
// No dependencies; used by the top level cable_robot_inverse_kinematics.
package crik_pkg;

    // Result field width and saturation range (signed Q10.16)
    localparam int OUT_W       = 27;
    localparam int OUT_TDATA_W = 88;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 27'sh3FFFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -27'sh4000000;

    // Configuration register index
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TOP_LEFT_PULLEY_X   = 3'd0,
        REG_TOP_LEFT_PULLEY_Y   = 3'd1,
        REG_TOP_RIGHT_PULLEY_X  = 3'd2,
        REG_TOP_RIGHT_PULLEY_Y  = 3'd3,
        REG_BOTTOM_PULLEY_X     = 3'd4,
        REG_FIRST_CABLE_OFFSET  = 3'd5,
        REG_SECOND_CABLE_OFFSET = 3'd6,
        REG_BOTTOM_ATTACH_DROP  = 3'd7
    } cfg_reg_t;

    // Reset geometry in Q7.16: pulleys at (0, 18) and (20, 18), bottom at 20, drop 1
    localparam int TOP_LEFT_X_RESET   = 0;
    localparam int TOP_Y_RESET        = 1179648;
    localparam int TOP_RIGHT_X_RESET  = 1310720;
    localparam int BOTTOM_X_RESET     = 1310720;
    localparam int CABLE_OFFSET_RESET = 0;
    localparam int ATTACH_DROP_RESET  = 65536;

endpackage

@@ hdl/crik_isqrt.sv @@
`timescale 1ns / 1ps
// Pipelined integer floor square root, one result bit per register stage.
// Stage loads come from the caller's valid chain; no package dependencies.
module crik_isqrt #(
    parameter int ROOT_W = 26
) (
    input  logic                  aclk,
    input  logic [ROOT_W-1:0]     stage_ld,   // load enable per stage, stage 0 first
    input  logic [2*ROOT_W-1:0]   rad_in,
    output logic [ROOT_W-1:0]     root_out
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    logic [RAD_W-1:0]  rad_next  [ROOT_W];
    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];

    logic [RAD_W-1:0]  rad_prev  [ROOT_W];
    logic [REM_W-1:0]  rem_prev  [ROOT_W];
    logic [ROOT_W-1:0] root_prev [ROOT_W];
    logic [REM_W-1:0]  rem_shift [ROOT_W];
    logic [REM_W-1:0]  trial     [ROOT_W];
    logic              fits      [ROOT_W];

    // One restoring step per stage: bring in two radicand bits, try root*4+1
    always_comb begin
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                rad_prev[k]  = rad_in;
                rem_prev[k]  = '0;
                root_prev[k] = '0;
            end else begin
                rad_prev[k]  = rad_reg[(k == 0) ? 0 : k-1];
                rem_prev[k]  = rem_reg[(k == 0) ? 0 : k-1];
                root_prev[k] = root_reg[(k == 0) ? 0 : k-1];
            end
            rem_shift[k] = {rem_prev[k][REM_W-3:0], rad_prev[k][RAD_W-1 -: 2]};
            trial[k]     = {root_prev[k], 2'b01};
            fits[k]      = (rem_shift[k] >= trial[k]);
            rem_next[k]  = fits[k] ? (rem_shift[k] - trial[k]) : rem_shift[k];
            root_next[k] = {root_prev[k][ROOT_W-2:0], fits[k]};
            rad_next[k]  = {rad_prev[k][RAD_W-3:0], 2'b00};
        end
    end

    // Advance each stage when its load enable is high
    always_ff @(posedge aclk) begin
        for (int k = 0; k < ROOT_W; k++) begin
            if (stage_ld[k]) begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root_out = root_reg[ROOT_W-1];

endmodule

@@ hdl/cable_robot_inverse_kinematics.sv @@
`timescale 1ns / 1ps
// Top level of the planar three-cable robot inverse kinematics pipeline.
// Depends on crik_pkg and crik_isqrt.
//
// Usage:
//   s_ channel: one target point per item, tdata = {target_y, target_x}.
//   m_ channel: one result per item, tdata = {cable_three, cable_two, cable_one}.
//   cfg_ channel: register index and data; always ready. Write geometry only
//   while no item is in flight.
// Depth: ROOT_W + 6 register stages, where ROOT_W is the root width (26 at
//   COORD_WIDTH = 24). The floor square roots take one stage per root bit;
//   four stages ahead of them form differences, magnitudes, squares and sums,
//   and two after them apply offsets and saturate.
// Throughput: one item per cycle. Every stage carries a valid bit and loads
//   whenever it or any stage after it is empty, so a stalled output register
//   still lets items fill the bubbles behind it; s_tready drops only when every
//   stage holds an item and m_tready is low.
// Reset: aresetn low clears all valid bits and restores the default geometry.
module cable_robot_inverse_kinematics #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input items
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // tdata: target_x, target_y (from bit 0 up), zero padded to bytes
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   s_tdata,
    // Result items
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // tdata: cable_one_length, cable_two_length, cable_three_length, zero padding
    output logic [crik_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // Configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [crik_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [COORD_WIDTH-1:0]               cfg_data
);

    localparam int OUT_W    = crik_pkg::OUT_W;
    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int MAG_W    = (DIFF_W > 32) ? 32 : DIFF_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = (SQ_W + 1 > 64) ? 64 : SQ_W + 1;
    localparam int ROOT_W   = (SUM_W + 1) / 2;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int E_W      = ((ROOT_W > COORD_WIDTH) ? ROOT_W : COORD_WIDTH) + 2;
    localparam int EXT_W    = (E_W > OUT_W) ? E_W : OUT_W;
    localparam int NSTG     = ROOT_W + 6;
    localparam int ST_ROOT  = 4;
    localparam int ST_OFS   = ROOT_W + 4;
    localparam int ST_SAT   = ROOT_W + 5;
    localparam int NUM_DIFF = 7;
    localparam int NUM_DIST = 4;
    localparam int NUM_OUT  = 3;

    // Difference slots; the attachment height is squared once for two distances
    localparam int D_ONE_X  = 0;
    localparam int D_ONE_Y  = 1;
    localparam int D_TWO_X  = 2;
    localparam int D_TWO_Y  = 3;
    localparam int D_ORG_X  = 4;
    localparam int D_ATT_Y  = 5;
    localparam int D_BOT_X  = 6;
    localparam int SUM_A [NUM_DIST] = '{D_ONE_X, D_TWO_X, D_ORG_X, D_BOT_X};
    localparam int SUM_B [NUM_DIST] = '{D_ONE_Y, D_TWO_Y, D_ATT_Y, D_ATT_Y};

    localparam logic [NSTG-1:0]   ALL_VALID = '1;
    localparam logic [DIFF_W-1:0] MAG_CAP   = DIFF_W'({MAG_W{1'b1}});
    localparam logic [SQ_W:0]     SUM_CAP   = (SQ_W + 1)'({SUM_W{1'b1}});
    localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(crik_pkg::OUT_MAX);
    localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(crik_pkg::OUT_MIN);

    // Geometry registers
    logic signed [COORD_WIDTH-1:0] p1x_reg, p1y_reg, p2x_reg, p2y_reg, pbx_reg;
    logic signed [COORD_WIDTH-1:0] off1_reg, off2_reg, drop_reg;

    // Pipeline control
    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] stage_adv;

    // Pipeline payload
    logic signed [DIFF_W-1:0] diff_reg [NUM_DIFF];
    logic signed [DIFF_W-1:0] diff_next [NUM_DIFF];
    logic [MAG_W-1:0]         mag_reg  [NUM_DIFF];
    logic [MAG_W-1:0]         mag_next [NUM_DIFF];
    logic [DIFF_W-1:0]        mag_abs  [NUM_DIFF];
    logic [SQ_W-1:0]          sq_reg   [NUM_DIFF];
    logic [SQ_W-1:0]          sq_next  [NUM_DIFF];
    logic [SQ_W:0]            sum_raw  [NUM_DIST];
    logic [SUM_W-1:0]         sum_reg  [NUM_DIST];
    logic [SUM_W-1:0]         sum_next [NUM_DIST];
    logic [ROOT_W-1:0]        root_w   [NUM_DIST];
    logic signed [E_W-1:0]    len_reg  [NUM_OUT];
    logic signed [E_W-1:0]    len_next [NUM_OUT];
    logic signed [EXT_W-1:0]  len_ext  [NUM_OUT];
    logic signed [OUT_W-1:0]  out_reg  [NUM_OUT];
    logic signed [OUT_W-1:0]  out_next [NUM_OUT];

    logic signed [COORD_WIDTH-1:0] x_in, y_in;

    assign x_in = $signed(s_tdata[COORD_WIDTH-1:0]);
    assign y_in = $signed(s_tdata[2*COORD_WIDTH-1 -: COORD_WIDTH]);

    // Configuration writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1x_reg  <= COORD_WIDTH'(crik_pkg::TOP_LEFT_X_RESET);
            p1y_reg  <= COORD_WIDTH'(crik_pkg::TOP_Y_RESET);
            p2x_reg  <= COORD_WIDTH'(crik_pkg::TOP_RIGHT_X_RESET);
            p2y_reg  <= COORD_WIDTH'(crik_pkg::TOP_Y_RESET);
            pbx_reg  <= COORD_WIDTH'(crik_pkg::BOTTOM_X_RESET);
            off1_reg <= COORD_WIDTH'(crik_pkg::CABLE_OFFSET_RESET);
            off2_reg <= COORD_WIDTH'(crik_pkg::CABLE_OFFSET_RESET);
            drop_reg <= COORD_WIDTH'(crik_pkg::ATTACH_DROP_RESET);
        end else if (cfg_valid) begin
            unique case (crik_pkg::cfg_reg_t'(cfg_index))
                crik_pkg::REG_TOP_LEFT_PULLEY_X:   p1x_reg  <= cfg_data;
                crik_pkg::REG_TOP_LEFT_PULLEY_Y:   p1y_reg  <= cfg_data;
                crik_pkg::REG_TOP_RIGHT_PULLEY_X:  p2x_reg  <= cfg_data;
                crik_pkg::REG_TOP_RIGHT_PULLEY_Y:  p2y_reg  <= cfg_data;
                crik_pkg::REG_BOTTOM_PULLEY_X:     pbx_reg  <= cfg_data;
                crik_pkg::REG_FIRST_CABLE_OFFSET:  off1_reg <= cfg_data;
                crik_pkg::REG_SECOND_CABLE_OFFSET: off2_reg <= cfg_data;
                crik_pkg::REG_BOTTOM_ATTACH_DROP:  drop_reg <= cfg_data;
            endcase
        end
    end

    // A stage may load when it or some stage after it is empty, or the output drains
    always_comb begin
        for (int k = 0; k < NSTG; k++) begin
            stage_adv[k] = m_tready || ((valid_reg | (ALL_VALID >> (NSTG - k))) != ALL_VALID);
        end
    end

    assign s_tready = stage_adv[0];
    assign m_tvalid = valid_reg[NSTG-1];

    // Advance valid bits with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (stage_adv[k]) begin
                    valid_reg[k] <= (k == 0) ? s_tvalid : valid_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    // Stage 0: coordinate differences
    always_comb begin
        diff_next[D_ONE_X] = DIFF_W'(x_in) - DIFF_W'(p1x_reg);
        diff_next[D_ONE_Y] = DIFF_W'(p1y_reg) - DIFF_W'(y_in);
        diff_next[D_TWO_X] = DIFF_W'(p2x_reg) - DIFF_W'(x_in);
        diff_next[D_TWO_Y] = DIFF_W'(p2y_reg) - DIFF_W'(y_in);
        diff_next[D_ORG_X] = DIFF_W'(x_in);
        diff_next[D_ATT_Y] = DIFF_W'(y_in) - DIFF_W'(drop_reg);
        diff_next[D_BOT_X] = DIFF_W'(pbx_reg) - DIFF_W'(x_in);
    end

    // Stage 1: magnitudes, clamped to the multiplier width
    // Stage 2: squares
    always_comb begin
        for (int i = 0; i < NUM_DIFF; i++) begin
            mag_abs[i]  = diff_reg[i][DIFF_W-1] ? (~diff_reg[i] + 1'b1) : diff_reg[i];
            mag_next[i] = (mag_abs[i] > MAG_CAP) ? MAG_CAP[MAG_W-1:0] : mag_abs[i][MAG_W-1:0];
            sq_next[i]  = SQ_W'(mag_reg[i]) * SQ_W'(mag_reg[i]);
        end
    end

    // Stage 3: sums of squares, saturated to SUM_W bits
    always_comb begin
        for (int j = 0; j < NUM_DIST; j++) begin
            sum_raw[j]  = {1'b0, sq_reg[SUM_A[j]]} + {1'b0, sq_reg[SUM_B[j]]};
            sum_next[j] = (sum_raw[j] > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : sum_raw[j][SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_DIFF; i++) begin
            if (stage_adv[0]) begin
                diff_reg[i] <= diff_next[i];
            end
            if (stage_adv[1]) begin
                mag_reg[i] <= mag_next[i];
            end
            if (stage_adv[2]) begin
                sq_reg[i] <= sq_next[i];
            end
        end
        for (int j = 0; j < NUM_DIST; j++) begin
            if (stage_adv[3]) begin
                sum_reg[j] <= sum_next[j];
            end
        end
    end

    // Square root stages, one per distance
    for (genvar j = 0; j < NUM_DIST; j++) begin : g_root
        crik_isqrt #(
            .ROOT_W   (ROOT_W)
        ) u_isqrt (
            .aclk     (aclk),
            .stage_ld (stage_adv[ST_ROOT +: ROOT_W]),
            .rad_in   (RAD_W'(sum_reg[j])),
            .root_out (root_w[j])
        );
    end

    // Apply cable offsets and join the two bottom distances
    always_comb begin
        len_next[0] = E_W'($signed({1'b0, root_w[0]})) - E_W'(off1_reg);
        len_next[1] = E_W'($signed({1'b0, root_w[1]})) - E_W'(off2_reg);
        len_next[2] = E_W'($signed({1'b0, root_w[2]})) + E_W'($signed({1'b0, root_w[3]}));
    end

    // Saturate to the result range
    always_comb begin
        for (int i = 0; i < NUM_OUT; i++) begin
            len_ext[i] = EXT_W'(len_reg[i]);
            if (len_ext[i] > SAT_HI) begin
                out_next[i] = crik_pkg::OUT_MAX;
            end else if (len_ext[i] < SAT_LO) begin
                out_next[i] = crik_pkg::OUT_MIN;
            end else begin
                out_next[i] = len_ext[i][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_OUT; i++) begin
            if (stage_adv[ST_OFS]) begin
                len_reg[i] <= len_next[i];
            end
            if (stage_adv[ST_SAT]) begin
                out_reg[i] <= out_next[i];
            end
        end
    end

    assign m_tdata = {{(crik_pkg::OUT_TDATA_W - NUM_OUT*OUT_W){1'b0}},
                      out_reg[2], out_reg[1], out_reg[0]};

endmodule

@@ verif/tb_cable_robot_inverse_kinematics.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for cable_robot_inverse_kinematics: streams target
// points, predicts the three cable lengths in-bench and checks every result item.
// Depends on crik_pkg and the RTL of the block.
module tb_cable_robot_inverse_kinematics;

    localparam int COORD_W       = 24;
    localparam int S_TDATA_W     = ((2*COORD_W+7)/8)*8;
    localparam int NUM_GEOM_REGS = 8;
    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 7;
    // Pipeline depth: 26 root stages plus six around them
    localparam int LATENCY       = 32;
    localparam int DRAIN_CYCLES  = 2*LATENCY;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 165;
    localparam int WARMUP_ITEMS  = 100;
    // ~1800 items plus drains, taken several times over
    localparam int RUN_LIMIT     = 500000;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    typedef logic signed [crik_pkg::OUT_W-1:0] cable_len_t;

    typedef struct {
        cable_len_t one;
        cable_len_t two;
        cable_len_t three;
    } cable_set_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } target_t;

    typedef enum int {
        IDLE_NONE,
        IDLE_FULL,
        IDLE_SPARSE
    } idle_mode_t;

    logic                                 aclk      = 1'b0;
    logic                                 aresetn   = 1'b0;
    logic                                 s_tvalid  = 1'b0;
    logic                                 s_tready;
    logic [S_TDATA_W-1:0]                 s_tdata   = '0;
    logic                                 m_tvalid;
    logic                                 m_tready  = 1'b0;
    logic [crik_pkg::OUT_TDATA_W-1:0]     m_tdata;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [crik_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [COORD_W-1:0]                   cfg_data  = '0;

    // Bench copy of the geometry registers
    logic signed [COORD_W-1:0]   geom [NUM_GEOM_REGS];

    target_t      pending_targets[$];
    cable_set_t   lengths_due[$];
    idle_mode_t   src_mode  = IDLE_NONE;
    idle_mode_t   sink_mode = IDLE_NONE;
    int           src_wait  = 0;
    int           sink_wait = 0;
    int           errors    = 0;
    int           cycle_count = 0;

    cable_robot_inverse_kinematics #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD/2) aclk = ~aclk;
    end

    // Floor square root, one result bit at a time from the top
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // Euclidean distance with clamped magnitudes and a saturating sum
    function automatic longint span_length(longint dx, longint dy);
        longint unsigned mx;
        longint unsigned my;
        longint unsigned sx;
        longint unsigned total;
        mx = (dx < 0) ? -dx : dx;
        my = (dy < 0) ? -dy : dy;
        if (mx > 64'hFFFF_FFFF) mx = 64'hFFFF_FFFF;
        if (my > 64'hFFFF_FFFF) my = 64'hFFFF_FFFF;
        sx    = mx * mx;
        total = sx + my * my;
        if (total < sx) total = '1;
        return longint'(floor_root(total));
    endfunction

    function automatic cable_len_t clamp_length(longint v);
        if (v > crik_pkg::OUT_MAX) return crik_pkg::OUT_MAX;
        if (v < crik_pkg::OUT_MIN) return crik_pkg::OUT_MIN;
        return cable_len_t'(v);
    endfunction

    // Cable lengths for one target point under the current geometry
    function automatic cable_set_t predict_lengths(logic signed [COORD_W-1:0] tx,
                                                   logic signed [COORD_W-1:0] ty);
        cable_set_t res;
        longint x;
        longint y;
        longint ay;
        x  = tx;
        y  = ty;
        ay = y - longint'(geom[crik_pkg::REG_BOTTOM_ATTACH_DROP]);
        res.one = clamp_length(
            span_length(x - longint'(geom[crik_pkg::REG_TOP_LEFT_PULLEY_X]),
                        longint'(geom[crik_pkg::REG_TOP_LEFT_PULLEY_Y]) - y)
            - longint'(geom[crik_pkg::REG_FIRST_CABLE_OFFSET]));
        res.two = clamp_length(
            span_length(longint'(geom[crik_pkg::REG_TOP_RIGHT_PULLEY_X]) - x,
                        longint'(geom[crik_pkg::REG_TOP_RIGHT_PULLEY_Y]) - y)
            - longint'(geom[crik_pkg::REG_SECOND_CABLE_OFFSET]));
        res.three = clamp_length(
            span_length(x, ay)
            + span_length(longint'(geom[crik_pkg::REG_BOTTOM_PULLEY_X]) - x, ay));
        return res;
    endfunction

    function automatic int draw_wait(idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 12);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] edge_coord();
        case ($urandom_range(0, 3))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] random_coord();
        case ($urandom_range(0, 2))
            0:       return COORD_W'($urandom);
            1:       return COORD_W'(int'($urandom_range(0, 4194304)) - 2097152);
            default: return edge_coord();
        endcase
    endfunction

    // Mix of raw random points, field extremes and points close to the anchors
    function automatic target_t random_target();
        target_t t;
        int      dx;
        int      dy;
        dx = int'($urandom_range(0, 512)) - 256;
        dy = int'($urandom_range(0, 512)) - 256;
        case ($urandom_range(0, 9))
            0, 1: begin
                t.x = edge_coord();
                t.y = edge_coord();
            end
            2, 3: begin
                case ($urandom_range(0, 3))
                    0: begin
                        t.x = COORD_W'(geom[crik_pkg::REG_TOP_LEFT_PULLEY_X] + dx);
                        t.y = COORD_W'(geom[crik_pkg::REG_TOP_LEFT_PULLEY_Y] + dy);
                    end
                    1: begin
                        t.x = COORD_W'(geom[crik_pkg::REG_TOP_RIGHT_PULLEY_X] + dx);
                        t.y = COORD_W'(geom[crik_pkg::REG_TOP_RIGHT_PULLEY_Y] + dy);
                    end
                    2: begin
                        t.x = COORD_W'(geom[crik_pkg::REG_BOTTOM_PULLEY_X] + dx);
                        t.y = COORD_W'(geom[crik_pkg::REG_BOTTOM_ATTACH_DROP] + dy);
                    end
                    default: begin
                        t.x = COORD_W'(dx);
                        t.y = COORD_W'(geom[crik_pkg::REG_BOTTOM_ATTACH_DROP] + dy);
                    end
                endcase
            end
            default: begin
                t.x = COORD_W'($urandom);
                t.y = COORD_W'($urandom);
            end
        endcase
        return t;
    endfunction

    task automatic add_target(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
        target_t t;
        t.x = x;
        t.y = y;
        pending_targets.push_back(t);
    endtask

    task automatic add_random(int count);
        for (int i = 0; i < count; i++) pending_targets.push_back(random_target());
    endtask

    // Points right on each pulley and on both attachment zeros
    task automatic add_anchor_points();
        add_target(geom[crik_pkg::REG_TOP_LEFT_PULLEY_X], geom[crik_pkg::REG_TOP_LEFT_PULLEY_Y]);
        add_target(geom[crik_pkg::REG_TOP_RIGHT_PULLEY_X],
                   geom[crik_pkg::REG_TOP_RIGHT_PULLEY_Y]);
        add_target(geom[crik_pkg::REG_BOTTOM_PULLEY_X], geom[crik_pkg::REG_BOTTOM_ATTACH_DROP]);
        add_target('0, geom[crik_pkg::REG_BOTTOM_ATTACH_DROP]);
    endtask

    // Hold until the sender is empty and every expected result is back
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_targets.size() != 0 || s_tvalid || lengths_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(crik_pkg::cfg_reg_t idx, logic signed [COORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        geom[idx] = val;
    endtask

    task automatic program_geometry(logic signed [COORD_W-1:0] setting [NUM_GEOM_REGS]);
        @(posedge aclk);
        for (int i = 0; i < NUM_GEOM_REGS; i++) write_reg(crik_pkg::cfg_reg_t'(i), setting[i]);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_length(string what, cable_len_t want, cable_len_t got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Drive target items from the pending queue with random gaps
    always @(posedge aclk) begin : drive_targets
        target_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
        end else begin
            if (s_tvalid && s_tready)
                lengths_due.push_back(predict_lengths(s_tdata[COORD_W-1:0],
                                                      s_tdata[2*COORD_W-1:COORD_W]));
            if (!s_tvalid || s_tready) begin
                if (src_wait > 0) begin
                    src_wait <= src_wait - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_targets.size() > 0) begin
                    item = pending_targets.pop_front();
                    s_tdata  <= {item.y, item.x};
                    s_tvalid <= 1'b1;
                    src_wait <= draw_wait(src_mode);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Take result items with random stalls and compare against the oldest expectation
    always @(posedge aclk) begin : collect_lengths
        cable_set_t want;
        int         n;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end else begin
            n = sink_wait;
            if (m_tvalid && m_tready) begin
                if (lengths_due.size() == 0) begin
                    $display("%0t: unexpected result item: expected none, actual %h",
                             $time, m_tdata);
                    errors++;
                end else begin
                    want = lengths_due.pop_front();
                    check_length("cable one", want.one, m_tdata[crik_pkg::OUT_W-1:0]);
                    check_length("cable two", want.two,
                                 m_tdata[2*crik_pkg::OUT_W-1:crik_pkg::OUT_W]);
                    check_length("cable three", want.three,
                                 m_tdata[3*crik_pkg::OUT_W-1:2*crik_pkg::OUT_W]);
                end
                n = draw_wait(sink_mode);
            end
            if (n > 0) begin
                m_tready  <= 1'b0;
                sink_wait <= n - 1;
            end else begin
                m_tready  <= 1'b1;
                sink_wait <= 0;
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, lengths_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic signed [COORD_W-1:0] setting [NUM_GEOM_REGS];
        geom[crik_pkg::REG_TOP_LEFT_PULLEY_X]   = COORD_W'(crik_pkg::TOP_LEFT_X_RESET);
        geom[crik_pkg::REG_TOP_LEFT_PULLEY_Y]   = COORD_W'(crik_pkg::TOP_Y_RESET);
        geom[crik_pkg::REG_TOP_RIGHT_PULLEY_X]  = COORD_W'(crik_pkg::TOP_RIGHT_X_RESET);
        geom[crik_pkg::REG_TOP_RIGHT_PULLEY_Y]  = COORD_W'(crik_pkg::TOP_Y_RESET);
        geom[crik_pkg::REG_BOTTOM_PULLEY_X]     = COORD_W'(crik_pkg::BOTTOM_X_RESET);
        geom[crik_pkg::REG_FIRST_CABLE_OFFSET]  = COORD_W'(crik_pkg::CABLE_OFFSET_RESET);
        geom[crik_pkg::REG_SECOND_CABLE_OFFSET] = COORD_W'(crik_pkg::CABLE_OFFSET_RESET);
        geom[crik_pkg::REG_BOTTOM_ATTACH_DROP]  = COORD_W'(crik_pkg::ATTACH_DROP_RESET);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed points under the reset geometry
        src_mode  = IDLE_FULL;
        sink_mode = IDLE_SPARSE;
        add_target('0, '0);
        add_target(COORD_MAX, COORD_MAX);
        add_target(COORD_MIN, COORD_MIN);
        add_target(COORD_MAX, COORD_MIN);
        add_target(COORD_MIN, COORD_MAX);
        add_target(COORD_MAX, '0);
        add_target('0, COORD_MAX);
        add_target(COORD_MIN, '0);
        add_target('0, COORD_MIN);
        add_target(24'sd1, 24'sd1);
        add_target('1, '1);
        add_target(24'h555555, 24'hAAAAAA);
        add_target(24'hAAAAAA, 24'h555555);
        add_anchor_points();
        add_random(WARMUP_ITEMS);
        wait_drained();

        for (int phase = 1; phase <= NUM_PHASES; phase++) begin
            // Pick the geometry: all-max, all-min, all-zero, big offsets, then random
            for (int i = 0; i < NUM_GEOM_REGS; i++) begin
                if (phase == 1)      setting[i] = COORD_MAX;
                else if (phase == 2) setting[i] = COORD_MIN;
                else if (phase == 3) setting[i] = '0;
                else                 setting[i] = random_coord();
            end
            if (phase == 4) begin
                setting[crik_pkg::REG_TOP_LEFT_PULLEY_X]  = COORD_W'(crik_pkg::TOP_LEFT_X_RESET);
                setting[crik_pkg::REG_TOP_LEFT_PULLEY_Y]  = COORD_W'(crik_pkg::TOP_Y_RESET);
                setting[crik_pkg::REG_TOP_RIGHT_PULLEY_X] = COORD_W'(crik_pkg::TOP_RIGHT_X_RESET);
                setting[crik_pkg::REG_TOP_RIGHT_PULLEY_Y] = COORD_W'(crik_pkg::TOP_Y_RESET);
                setting[crik_pkg::REG_BOTTOM_PULLEY_X]    = COORD_W'(crik_pkg::BOTTOM_X_RESET);
                setting[crik_pkg::REG_FIRST_CABLE_OFFSET]  = COORD_MAX;
                setting[crik_pkg::REG_SECOND_CABLE_OFFSET] = COORD_MIN;
                setting[crik_pkg::REG_BOTTOM_ATTACH_DROP]  = COORD_MIN;
            end

            if (phase == 1) begin
                src_mode  = IDLE_NONE;
                sink_mode = IDLE_NONE;
            end else if (phase == 2) begin
                src_mode  = IDLE_FULL;
                sink_mode = IDLE_FULL;
            end else begin
                src_mode  = idle_mode_t'($urandom_range(0, 2));
                sink_mode = idle_mode_t'($urandom_range(0, 2));
            end

            program_geometry(setting);
            @(negedge aclk);
            add_anchor_points();
            add_random(PHASE_ITEMS/2);
            // Sender holds off mid-phase until the pipeline is empty
            wait_drained();
            add_random(PHASE_ITEMS - PHASE_ITEMS/2);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/crik_pkg.sv
hdl/crik_isqrt.sv
hdl/cable_robot_inverse_kinematics.sv
verif/tb_cable_robot_inverse_kinematics.sv
